// ===== src/sas_pkg.sv =====
// ----------------------------------------------------------------------------
// sas_pkg: shared types and helpers for the sprite alpha frame statistics block
// Holds the pixel and result layouts, the configuration write bundle, the
// register indexes and the small saturating and size-clamping helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package sas_pkg;

    // Largest frame dimension in pixels; sizes above it are clamped.
    localparam int MAX_DIM   = 4096;
    localparam int POS_W     = $clog2(MAX_DIM);
    localparam int DIM_W     = POS_W + 1;
    localparam int TALLY_W   = 25;
    localparam int EDGE_W    = 13;
    localparam int CHAN_W    = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 13;

    localparam logic [POS_W-1:0]   POS_MAX    = POS_W'(MAX_DIM - 1);
    localparam logic [DIM_W-1:0]   DIM_LIMIT  = DIM_W'(MAX_DIM);
    localparam logic [TALLY_W-1:0] TALLY_MAX  = '1;
    localparam logic [EDGE_W-1:0]  EDGE_MAX   = '1;
    localparam logic [CHAN_W-1:0]  ALPHA_FULL = '1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    // Reset value of both size registers, stored as last position (64 - 1).
    localparam logic [POS_W-1:0] DIM_RESET_LAST = POS_W'(63);

    // Pixel as it sits on the input bus, red in the lowest byte.
    typedef struct packed {
        logic [CHAN_W-1:0] alpha;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } pixel_t;

    // Frame statistics as they sit on the output bus, transparent count lowest.
    typedef struct packed {
        logic [EDGE_W-1:0]  box_height;
        logic [EDGE_W-1:0]  box_width;
        logic [POS_W-1:0]   box_y;
        logic [POS_W-1:0]   box_x;
        logic [EDGE_W-1:0]  bottom_edge_visible;
        logic [EDGE_W-1:0]  right_edge_visible;
        logic [EDGE_W-1:0]  top_edge_visible;
        logic [EDGE_W-1:0]  left_edge_visible;
        logic [TALLY_W-1:0] opaque_count;
        logic [TALLY_W-1:0] residue_count;
        logic [TALLY_W-1:0] transparent_count;
    } stats_t;

    typedef struct packed {
        logic   frame_empty;
        stats_t stats;
    } result_t;

    localparam int STATS_W = $bits(stats_t);
    localparam int TDATA_W = ((STATS_W + 7) / 8) * 8;

    typedef struct packed {
        logic                 en;
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_DAT_W-1:0] data;
    } cfg_write_t;

    // Turns a raw size register value into the last valid position.
    function automatic logic [POS_W-1:0] dim_last(input logic [CFG_DAT_W-1:0] v);
        logic [DIM_W-1:0] d;
        begin
            d = DIM_W'(v);
            if (d == '0) begin
                dim_last = '0;
            end else if (d > DIM_LIMIT) begin
                dim_last = POS_MAX;
            end else begin
                dim_last = POS_W'(d - DIM_W'(1));
            end
        end
    endfunction

    function automatic logic [TALLY_W-1:0] tally_inc(input logic [TALLY_W-1:0] c);
        tally_inc = (c == TALLY_MAX) ? c : c + TALLY_W'(1);
    endfunction

    function automatic logic [EDGE_W-1:0] edge_inc(input logic [EDGE_W-1:0] c);
        edge_inc = (c == EDGE_MAX) ? c : c + EDGE_W'(1);
    endfunction

endpackage

`default_nettype wire

// ===== src/sas_pix_reg.sv =====
// ----------------------------------------------------------------------------
// sas_pix_reg: input pixel register
// Captures one pixel per transaction and holds it until the statistics stage
// consumes it; a new pixel may enter in the same cycle the held one leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module sas_pix_reg (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire sas_pkg::pixel_t s_pixel,
    input  wire logic            consume,
    output logic                 pix_valid,
    output sas_pkg::pixel_t      pix_data
);

    logic            valid_reg;
    logic            valid_next;
    sas_pkg::pixel_t data_reg;

    assign s_tready = !valid_reg || consume;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_tvalid && s_tready) begin
            data_reg <= s_pixel;
        end
    end

    assign pix_valid = valid_reg;
    assign pix_data  = data_reg;

endmodule

`default_nettype wire

// ===== src/sas_accum.sv =====
// ----------------------------------------------------------------------------
// sas_accum: frame position tracking and statistics accumulation
// Keeps column and row, the per-frame tallies and the visible bounding box,
// and forms the frame result from the updated values on the last pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module sas_accum (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire sas_pkg::cfg_write_t cfg,
    input  wire logic                step,
    input  wire sas_pkg::pixel_t     pix,
    output logic                     at_frame_end,
    output sas_pkg::result_t         result
);

    localparam int POS_W   = sas_pkg::POS_W;
    localparam int TALLY_W = sas_pkg::TALLY_W;
    localparam int EDGE_W  = sas_pkg::EDGE_W;

    logic [POS_W-1:0]   wlast_reg, wlast_next;
    logic [POS_W-1:0]   hlast_reg, hlast_next;
    logic [POS_W-1:0]   col_reg, col_next;
    logic [POS_W-1:0]   row_reg, row_next;
    logic [POS_W-1:0]   lx_reg, lx_next;
    logic [POS_W-1:0]   ly_reg, ly_next;
    logic [POS_W-1:0]   gx_reg, gx_next;
    logic [POS_W-1:0]   gy_reg, gy_next;
    logic               seen_reg, seen_next;
    logic [TALLY_W-1:0] transp_reg, transp_next;
    logic [TALLY_W-1:0] resid_reg, resid_next;
    logic [TALLY_W-1:0] opaque_reg, opaque_next;
    logic [EDGE_W-1:0]  left_reg, left_next;
    logic [EDGE_W-1:0]  top_reg, top_next;
    logic [EDGE_W-1:0]  right_reg, right_next;
    logic [EDGE_W-1:0]  bottom_reg, bottom_next;

    logic last_col;
    logic last_row;
    logic transparent;
    logic visible;

    // Position stays inside the frame: every size change clears it.
    assign last_col     = (col_reg == wlast_reg);
    assign last_row     = (row_reg == hlast_reg);
    assign at_frame_end = last_col && last_row;
    assign transparent  = (pix.alpha == '0);
    assign visible      = !transparent;

    // Pixel update; these values also feed the result of the last pixel.
    always_comb begin
        lx_next     = lx_reg;
        ly_next     = ly_reg;
        gx_next     = gx_reg;
        gy_next     = gy_reg;
        seen_next   = seen_reg;
        transp_next = transp_reg;
        resid_next  = resid_reg;
        opaque_next = opaque_reg;
        left_next   = left_reg;
        top_next    = top_reg;
        right_next  = right_reg;
        bottom_next = bottom_reg;
        if (transparent) begin
            transp_next = sas_pkg::tally_inc(transp_reg);
            if ((pix.red != '0) || (pix.green != '0) || (pix.blue != '0)) begin
                resid_next = sas_pkg::tally_inc(resid_reg);
            end
        end else begin
            if (!seen_reg || col_reg < lx_reg) begin
                lx_next = col_reg;
            end
            if (!seen_reg || row_reg < ly_reg) begin
                ly_next = row_reg;
            end
            if (!seen_reg || col_reg > gx_reg) begin
                gx_next = col_reg;
            end
            if (!seen_reg || row_reg > gy_reg) begin
                gy_next = row_reg;
            end
            seen_next = 1'b1;
            if (col_reg == '0) begin
                left_next = sas_pkg::edge_inc(left_reg);
            end
            if (row_reg == '0) begin
                top_next = sas_pkg::edge_inc(top_reg);
            end
            if (last_col) begin
                right_next = sas_pkg::edge_inc(right_reg);
            end
            if (last_row) begin
                bottom_next = sas_pkg::edge_inc(bottom_reg);
            end
            if (pix.alpha == sas_pkg::ALPHA_FULL) begin
                opaque_next = sas_pkg::tally_inc(opaque_reg);
            end
        end
    end

    always_comb begin
        result.frame_empty                     = !seen_next;
        result.stats.transparent_count         = transp_next;
        result.stats.residue_count             = resid_next;
        result.stats.opaque_count              = opaque_next;
        result.stats.left_edge_visible         = left_next;
        result.stats.top_edge_visible          = top_next;
        result.stats.right_edge_visible        = right_next;
        result.stats.bottom_edge_visible       = bottom_next;
        if (seen_next) begin
            result.stats.box_x      = lx_next;
            result.stats.box_y      = ly_next;
            result.stats.box_width  = EDGE_W'(gx_next) - EDGE_W'(lx_next) + EDGE_W'(1);
            result.stats.box_height = EDGE_W'(gy_next) - EDGE_W'(ly_next) + EDGE_W'(1);
        end else begin
            result.stats.box_x      = '0;
            result.stats.box_y      = '0;
            result.stats.box_width  = '0;
            result.stats.box_height = '0;
        end
    end

    always_comb begin
        wlast_next = wlast_reg;
        hlast_next = hlast_reg;
        if (cfg.en) begin
            case (cfg.index)
                sas_pkg::CFG_FRAME_WIDTH:  wlast_next = sas_pkg::dim_last(cfg.data);
                sas_pkg::CFG_FRAME_HEIGHT: hlast_next = sas_pkg::dim_last(cfg.data);
                default: ;
            endcase
        end
        if (last_col) begin
            col_next = '0;
            row_next = row_reg + POS_W'(1);
        end else begin
            col_next = col_reg + POS_W'(1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg.en || (step && at_frame_end)) begin
            col_reg    <= '0;
            row_reg    <= '0;
            lx_reg     <= !aresetn ? sas_pkg::DIM_RESET_LAST : wlast_next;
            ly_reg     <= !aresetn ? sas_pkg::DIM_RESET_LAST : hlast_next;
            gx_reg     <= '0;
            gy_reg     <= '0;
            seen_reg   <= 1'b0;
            transp_reg <= '0;
            resid_reg  <= '0;
            opaque_reg <= '0;
            left_reg   <= '0;
            top_reg    <= '0;
            right_reg  <= '0;
            bottom_reg <= '0;
        end else if (step) begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            lx_reg     <= lx_next;
            ly_reg     <= ly_next;
            gx_reg     <= gx_next;
            gy_reg     <= gy_next;
            seen_reg   <= seen_next;
            transp_reg <= transp_next;
            resid_reg  <= resid_next;
            opaque_reg <= opaque_next;
            left_reg   <= left_next;
            top_reg    <= top_next;
            right_reg  <= right_next;
            bottom_reg <= bottom_next;
        end
        if (!aresetn) begin
            wlast_reg <= sas_pkg::DIM_RESET_LAST;
            hlast_reg <= sas_pkg::DIM_RESET_LAST;
        end else begin
            wlast_reg <= wlast_next;
            hlast_reg <= hlast_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/sas_out_reg.sv =====
// ----------------------------------------------------------------------------
// sas_out_reg: frame result register
// Holds one finished frame result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sas_out_reg (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             load,
    input  wire sas_pkg::result_t load_data,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output sas_pkg::result_t      m_result
);

    logic             valid_reg;
    logic             valid_next;
    sas_pkg::result_t data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_result = data_reg;

endmodule

`default_nettype wire

// ===== src/sprite_alpha_frame_stats.sv =====
// ----------------------------------------------------------------------------
// sprite_alpha_frame_stats: per-frame alpha statistics and visible bounds
// Counts transparent, residue and opaque pixels, visible pixels on each frame
// edge, and the bounding box of visible pixels, one result per frame.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Payload
// s_axis    in         one RGBA8 pixel per transaction, raster order
// m_axis    out        one statistics record per frame, on its last pixel
// cfg       in         frame_width (index 0) and frame_height (index 1)
//
// The block sustains one pixel per clock. A pixel is registered on entry and
// folded into the statistics as it leaves that register, and a frame's result
// is registered in the result register from which m_axis is driven.
// Reset is synchronous and active low; it restores a 64 by 64 frame size and
// clears all counters. Any configuration write restarts the current frame.
// Upstream stalls only when the last pixel of a frame finds the result
// register still full and not being drained.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_alpha_frame_stats (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // Pixel input.
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // tdata fields from bit 0: red[7:0], green[15:8], blue[23:16], alpha[31:24].
    input  wire logic [$bits(sas_pkg::pixel_t)-1:0]   s_tdata,
    // Frame result.
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // tdata fields from bit 0: transparent_count[24:0], residue_count[49:25],
    // opaque_count[74:50], left_edge_visible[87:75], top_edge_visible[100:88],
    // right_edge_visible[113:101], bottom_edge_visible[126:114],
    // box_x[138:127], box_y[150:139], box_width[163:151],
    // box_height[176:164], zero fill above.
    output logic [sas_pkg::TDATA_W-1:0]               m_tdata,
    // tuser fields from bit 0: frame_empty[0].
    output logic                                      m_tuser,
    // Configuration write port.
    input  wire logic                                 cfg_wr_en,
    input  wire logic [sas_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [sas_pkg::CFG_DAT_W-1:0]        cfg_data
);

    logic                pix_valid;
    sas_pkg::pixel_t     pix_data;
    logic                step;
    logic                at_frame_end;
    sas_pkg::result_t    frame_result;
    sas_pkg::result_t    out_result;
    sas_pkg::cfg_write_t cfg;

    assign cfg.en    = cfg_wr_en;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    // The held pixel moves on unless it closes a frame whose result has
    // nowhere to go this cycle.
    assign step = pix_valid && (!at_frame_end || !m_tvalid || m_tready);

    sas_pix_reg u_pix_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_pixel   (sas_pkg::pixel_t'(s_tdata)),
        .consume   (step),
        .pix_valid (pix_valid),
        .pix_data  (pix_data)
    );

    sas_accum u_accum (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .step         (step),
        .pix          (pix_data),
        .at_frame_end (at_frame_end),
        .result       (frame_result)
    );

    sas_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (step && at_frame_end),
        .load_data (frame_result),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_result  (out_result)
    );

    assign m_tdata = sas_pkg::TDATA_W'(out_result.stats);
    assign m_tuser = out_result.frame_empty;

endmodule

`default_nettype wire
